FILE: src/mpsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsu_pkg
// Shared types and constants of the message passing process scheduler.
// ----------------------------------------------------------------------------
package mpsu_pkg;

  localparam int unsigned MaxProcs = 32;
  localparam int unsigned NumPrio  = 3;
  localparam int unsigned NumIrqs  = 32;

  localparam int unsigned PidW  = $clog2(MaxProcs);
  localparam int unsigned LinkW = PidW + 1;
  localparam int unsigned CntW  = $clog2(MaxProcs + 1);
  localparam int unsigned PrioW = $clog2(NumPrio + 1);
  localparam int unsigned QW    = (NumPrio > 1) ? $clog2(NumPrio) : 1;
  localparam int unsigned IrqW  = (NumIrqs > 1) ? $clog2(NumIrqs) : 1;

  localparam logic [7:0] AnyTypeReset   = 8'hff;
  localparam logic [7:0] IntrTypeReset  = 8'd2;
  localparam logic [7:0] ReplyTypeReset = 8'd1;

  // Null link: top bit set.
  localparam logic [LinkW-1:0] LinkNil = {1'b1, {PidW{1'b0}}};

  typedef enum logic [3:0] {
    ActCreate  = 4'd0,
    ActYield   = 4'd1,
    ActSend    = 4'd2,
    ActReceive = 4'd3,
    ActSendRec = 4'd4,
    ActExit    = 4'd5,
    ActConnect = 4'd6,
    ActSetPrio = 4'd7,
    ActIntr    = 4'd8,
    ActPreempt = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrBadDest  = 3'd1,
    ErrBadPrio  = 3'd2,
    ErrBadIntr  = 3'd3,
    ErrTooMany  = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    StDead      = 3'd0,
    StActive    = 3'd1,
    StSending   = 3'd2,
    StReceiving = 3'd3,
    StSendRec   = 3'd4,
    StIdling    = 3'd5
  } status_e;

  localparam logic [1:0] CfgAnyType   = 2'd0;
  localparam logic [1:0] CfgIntrType  = 2'd1;
  localparam logic [1:0] CfgReplyType = 2'd2;

  typedef struct packed {
    status_e          status;
    logic [PrioW-1:0] prio;
    logic [7:0]       wanted;
    logic             pend;
    logic [LinkW-1:0] link;
    logic [LinkW-1:0] sqh;
  } entry_t;

  typedef struct packed {
    logic [PidW-1:0] raddr;
    logic            we;
    logic [PidW-1:0] waddr;
    entry_t          wdata;
  } ptab_req_t;

endpackage

FILE: src/mpsu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsu_cmd_if / mpsu_res_if
// Valid/ready channels for kernel requests and their results.
// ----------------------------------------------------------------------------
interface mpsu_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [4:0] target_pid;
  logic [7:0] msg_type;
  logic [4:0] irq_number;
  logic [1:0] priority_value;

  modport source (output valid, action, target_pid, msg_type, irq_number, priority_value,
                  input ready);
  modport sink (input valid, action, target_pid, msg_type, irq_number, priority_value,
                output ready);
endinterface

interface mpsu_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] current_pid;
  logic       delivered;
  logic [4:0] deliver_to;
  logic [4:0] deliver_from;
  logic       from_hardware;
  logic [7:0] deliver_type;
  logic [4:0] new_pid;
  logic [2:0] error;

  modport source (output valid, current_pid, delivered, deliver_to, deliver_from,
                  from_hardware, deliver_type, new_pid, error, input ready);
  modport sink (input valid, current_pid, delivered, deliver_to, deliver_from,
                from_hardware, deliver_type, new_pid, error, output ready);
endinterface

FILE: src/mpsu_ptab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsu_ptab
// Process table: one read and one write port, registered read, write-through.
// ----------------------------------------------------------------------------
module mpsu_ptab (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpsu_pkg::ptab_req_t req_i,
  output mpsu_pkg::entry_t    rdata_o
);

  mpsu_pkg::entry_t                 mem_q [mpsu_pkg::MaxProcs];
  logic [mpsu_pkg::MaxProcs-1:0]    valid_q;
  mpsu_pkg::entry_t                 rd_q;
  logic                             rd_valid_q;
  logic                             rd_zero_q;
  logic                             fwd;
  mpsu_pkg::entry_t                 rst_entry;

  assign fwd = req_i.we && (req_i.waddr == req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= fwd ? req_i.wdata : mem_q[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_zero_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rd_valid_q <= fwd | valid_q[req_i.raddr];
      rd_zero_q  <= (req_i.raddr == '0);
    end
  end

  // Entries never written read as their reset value.
  always_comb begin
    rst_entry.status = rd_zero_q ? mpsu_pkg::StIdling : mpsu_pkg::StDead;
    rst_entry.prio   = rd_zero_q ? mpsu_pkg::PrioW'(mpsu_pkg::NumPrio)
                                 : mpsu_pkg::PrioW'(mpsu_pkg::NumPrio - 1);
    rst_entry.wanted = mpsu_pkg::AnyTypeReset;
    rst_entry.pend   = 1'b0;
    rst_entry.link   = mpsu_pkg::LinkNil;
    rst_entry.sqh    = mpsu_pkg::LinkNil;
  end

  assign rdata_o = rd_valid_q ? rd_q : rst_entry;

endmodule

FILE: src/message_passing_process_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_passing_process_scheduler_unit
// Rendezvous message-passing kernel with fixed-priority FIFO ready queues.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  cmd_i   | in  | valid/ready        | action, target_pid, msg_type, irq_number,
//          |     |                    | priority_value
//  res_o   | out | valid/ready        | current_pid, delivery fields, new_pid, error
//  cfg     | in  | cfg_we_i (no wait) | cfg_index_i, cfg_data_i
//
// One request at a time. A request runs through the sequencer states from acceptance
// to a valid result, plus one list step for each sender queue entry visited. The walk
// is paced by the single read port of the process table, whose registered read gives
// one list step per cycle.
// Reset clears all control state at once; table entries never written read as
// their reset value through per-entry valid bits, so no clearing pass is run.
// A finished result waits in the output register; the next request is taken
// while it waits, and the sequencer only stalls at its end if it is still held.
// ----------------------------------------------------------------------------
module message_passing_process_scheduler_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpsu_cmd_if.sink          cmd_i,
  mpsu_res_if.source        res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);

  localparam int unsigned PidW  = mpsu_pkg::PidW;
  localparam int unsigned LinkW = mpsu_pkg::LinkW;
  localparam int unsigned CntW  = mpsu_pkg::CntW;
  localparam int unsigned PrioW = mpsu_pkg::PrioW;
  localparam int unsigned QW    = mpsu_pkg::QW;
  localparam int unsigned IrqW  = mpsu_pkg::IrqW;
  localparam int unsigned NS    = 33;

  typedef enum logic [NS-1:0] {
    SIdle    = NS'(1) << 0,
    SDecode  = NS'(1) << 1,
    SCrWr    = NS'(1) << 2,
    SYpGo    = NS'(1) << 3,
    SPrStart = NS'(1) << 4,
    SPrWr    = NS'(1) << 5,
    SPrQ     = NS'(1) << 6,
    SPrTWr   = NS'(1) << 7,
    SPnA     = NS'(1) << 8,
    SPnB     = NS'(1) << 9,
    SSdChk   = NS'(1) << 10,
    SSrRd    = NS'(1) << 11,
    SSrWr    = NS'(1) << 12,
    SSjRd    = NS'(1) << 13,
    SSjWr    = NS'(1) << 14,
    SJsRd    = NS'(1) << 15,
    SJsChk   = NS'(1) << 16,
    SJsWalk  = NS'(1) << 17,
    SRcChk   = NS'(1) << 18,
    SRcWalk  = NS'(1) << 19,
    SRcUlRd  = NS'(1) << 20,
    SRcUlWr  = NS'(1) << 21,
    SRcSRd   = NS'(1) << 22,
    SRcSWr   = NS'(1) << 23,
    SRcBkRd  = NS'(1) << 24,
    SRcBkWr  = NS'(1) << 25,
    SExWr    = NS'(1) << 26,
    SCnWr    = NS'(1) << 27,
    SSpWr    = NS'(1) << 28,
    SInChk   = NS'(1) << 29,
    SInCur   = NS'(1) << 30,
    SInCur2  = NS'(1) << 31,
    SFin     = NS'(1) << 32
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  // Request fields.
  logic [3:0]       act_q, act_d;
  logic [PidW-1:0]  dest_q, dest_d;
  logic [7:0]       type_q, type_d;
  logic [4:0]       irq_q, irq_d;
  logic [1:0]       pval_q, pval_d;
  logic [PidW-1:0]  cur_q, cur_d;

  // Scheduler state held in flops.
  logic [PidW-1:0]  running_q, running_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [LinkW-1:0] head_q [mpsu_pkg::NumPrio];
  logic [LinkW-1:0] head_d [mpsu_pkg::NumPrio];
  logic [LinkW-1:0] tail_q [mpsu_pkg::NumPrio];
  logic [LinkW-1:0] tail_d [mpsu_pkg::NumPrio];
  logic [PidW-1:0]  hdl_q [mpsu_pkg::NumIrqs];
  logic [PidW-1:0]  hdl_d [mpsu_pkg::NumIrqs];
  logic [7:0]       any_q, intr_q, reply_q;

  // Sequencer working registers.
  logic [PidW-1:0]  pp_q, pp_d;
  logic [PrioW-1:0] pprio_q, pprio_d;
  logic [PidW-1:0]  ptr_q, ptr_d;
  logic [LinkW-1:0] prev_q, prev_d;
  logic [CntW-1:0]  steps_q, steps_d;
  logic [QW-1:0]    pnq_q, pnq_d;
  mpsu_pkg::entry_t ent_q, ent_d;

  // Result being built.
  logic             dlv_q, dlv_d, hw_q, hw_d;
  logic [PidW-1:0]  dto_q, dto_d, dfrom_q, dfrom_d, npid_q, npid_d;
  logic [7:0]       dtype_q, dtype_d;
  mpsu_pkg::err_e   err_q, err_d;

  // Output register.
  logic             ov_q;
  logic [4:0]       o_cur_q, o_dto_q, o_dfrom_q, o_npid_q;
  logic             o_dlv_q, o_hw_q;
  logic [7:0]       o_dtype_q;
  logic [2:0]       o_err_q;
  logic             load_out;

  mpsu_pkg::ptab_req_t req;
  mpsu_pkg::entry_t    rd;
  mpsu_pkg::entry_t    wr;

  logic             pn_found;
  logic [QW-1:0]    pn_idx;
  logic [IrqW-1:0]  irq_idx;
  logic [QW-1:0]    pq;
  logic             any_t;
  logic [CntW-1:0]  steps_n;

  mpsu_ptab u_ptab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rd)
  );

  assign cmd_i.ready = (state_q == SIdle);
  assign irq_idx     = IrqW'(irq_q);
  assign pq          = QW'(pprio_q);
  assign any_t       = (type_q == any_q);
  assign steps_n     = steps_q + CntW'(1);

  function automatic logic takes(mpsu_pkg::entry_t e, logic [7:0] t, logic [7:0] any_code);
    return (e.status == mpsu_pkg::StReceiving) && ((e.wanted == any_code) || (e.wanted == t));
  endfunction

  // First non-empty ready queue, highest priority first.
  always_comb begin
    pn_found = 1'b0;
    pn_idx   = '0;
    for (int q = mpsu_pkg::NumPrio - 1; q >= 0; q--) begin
      if (!head_q[q][PidW]) begin
        pn_found = 1'b1;
        pn_idx   = QW'(q);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    act_d     = act_q;
    dest_d    = dest_q;
    type_d    = type_q;
    irq_d     = irq_q;
    pval_d    = pval_q;
    cur_d     = cur_q;
    running_d = running_q;
    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    hdl_d     = hdl_q;
    pp_d      = pp_q;
    pprio_d   = pprio_q;
    ptr_d     = ptr_q;
    prev_d    = prev_q;
    steps_d   = steps_q;
    pnq_d     = pnq_q;
    ent_d     = ent_q;
    dlv_d     = dlv_q;
    hw_d      = hw_q;
    dto_d     = dto_q;
    dfrom_d   = dfrom_q;
    npid_d    = npid_q;
    dtype_d   = dtype_q;
    err_d     = err_q;
    load_out  = 1'b0;

    wr        = rd;
    req.raddr = cur_q;
    req.we    = 1'b0;
    req.waddr = cur_q;
    req.wdata = wr;

    unique case (state_q)
      SIdle: begin
        if (cmd_i.valid) begin
          act_d   = cmd_i.action;
          dest_d  = cmd_i.target_pid;
          type_d  = cmd_i.msg_type;
          irq_d   = cmd_i.irq_number;
          pval_d  = cmd_i.priority_value;
          cur_d   = running_q;
          dlv_d   = 1'b0;
          hw_d    = 1'b0;
          dto_d   = '0;
          dfrom_d = '0;
          npid_d  = '0;
          dtype_d = '0;
          err_d   = mpsu_pkg::ErrNone;
          state_d = SDecode;
        end
      end

      SDecode: begin
        case (act_q)
          mpsu_pkg::ActCreate: begin
            if (count_q >= CntW'(mpsu_pkg::MaxProcs)) begin
              err_d   = mpsu_pkg::ErrTooMany;
              state_d = SFin;
            end else begin
              state_d = SCrWr;
            end
          end
          mpsu_pkg::ActYield, mpsu_pkg::ActPreempt: state_d = SYpGo;
          mpsu_pkg::ActSend, mpsu_pkg::ActSendRec: begin
            req.raddr = dest_q;
            if (CntW'(dest_q) >= count_q) begin
              err_d   = mpsu_pkg::ErrBadDest;
              state_d = SFin;
            end else begin
              state_d = SSdChk;
            end
          end
          mpsu_pkg::ActReceive: state_d = SRcChk;
          mpsu_pkg::ActExit:    state_d = SExWr;
          mpsu_pkg::ActConnect: begin
            state_d = (32'(irq_q) >= mpsu_pkg::NumIrqs) ? SFin : SCnWr;
          end
          mpsu_pkg::ActSetPrio: begin
            if (32'(pval_q) > mpsu_pkg::NumPrio - 1) begin
              err_d   = mpsu_pkg::ErrBadPrio;
              state_d = SFin;
            end else begin
              state_d = SSpWr;
            end
          end
          mpsu_pkg::ActIntr: begin
            req.raddr = hdl_q[irq_idx];
            if ((32'(irq_q) >= mpsu_pkg::NumIrqs) || (hdl_q[irq_idx] == '0)) begin
              err_d   = mpsu_pkg::ErrBadIntr;
              state_d = SFin;
            end else begin
              state_d = SInChk;
            end
          end
          default: state_d = SFin;
        endcase
      end

      // Create: write the whole fresh entry, then append it to its queue.
      SCrWr: begin
        wr.status = mpsu_pkg::StActive;
        wr.prio   = PrioW'(mpsu_pkg::NumPrio - 1);
        wr.wanted = any_q;
        wr.pend   = 1'b0;
        wr.link   = mpsu_pkg::LinkNil;
        wr.sqh    = mpsu_pkg::LinkNil;
        req.we    = 1'b1;
        req.waddr = PidW'(count_q);
        req.wdata = wr;
        npid_d    = PidW'(count_q);
        count_d   = count_q + CntW'(1);
        pp_d      = PidW'(count_q);
        pprio_d   = PrioW'(mpsu_pkg::NumPrio - 1);
        ret_d     = SFin;
        state_d   = SPrQ;
      end

      SYpGo: begin
        pp_d    = cur_q;
        pprio_d = rd.prio;
        ret_d   = SPnA;
        state_d = SPrStart;
      end

      // Make ready: mark active, unlink, append at the queue tail.
      SPrStart: begin
        req.raddr = pp_q;
        state_d   = (32'(pprio_q) >= mpsu_pkg::NumPrio) ? ret_q : SPrWr;
      end
      SPrWr: begin
        wr.status = mpsu_pkg::StActive;
        wr.link   = mpsu_pkg::LinkNil;
        req.we    = 1'b1;
        req.waddr = pp_q;
        req.wdata = wr;
        state_d   = SPrQ;
      end
      SPrQ: begin
        req.raddr = tail_q[pq][PidW-1:0];
        if (head_q[pq][PidW] || tail_q[pq][PidW]) begin
          head_d[pq] = {1'b0, pp_q};
          tail_d[pq] = {1'b0, pp_q};
          state_d    = ret_q;
        end else begin
          state_d    = SPrTWr;
        end
      end
      SPrTWr: begin
        wr.link    = {1'b0, pp_q};
        req.we     = 1'b1;
        req.waddr  = tail_q[pq][PidW-1:0];
        req.wdata  = wr;
        tail_d[pq] = {1'b0, pp_q};
        state_d    = ret_q;
      end

      // Pick next: pop the head of the first non-empty queue.
      SPnA: begin
        req.raddr = head_q[pn_idx][PidW-1:0];
        pnq_d     = pn_idx;
        if (pn_found) begin
          state_d   = SPnB;
        end else begin
          running_d = '0;
          state_d   = SFin;
        end
      end
      SPnB: begin
        running_d     = head_q[pnq_q][PidW-1:0];
        head_d[pnq_q] = rd.link;
        state_d       = SFin;
      end

      SSdChk: begin
        if (rd.status == mpsu_pkg::StDead) begin
          err_d   = mpsu_pkg::ErrBadDest;
          state_d = SFin;
        end else if (takes(rd, type_q, any_q)) begin
          dlv_d   = 1'b1;
          dto_d   = dest_q;
          dfrom_d = cur_q;
          dtype_d = type_q;
          pp_d    = dest_q;
          pprio_d = rd.prio;
          ret_d   = (act_q == mpsu_pkg::ActSendRec) ? SSrRd : SFin;
          state_d = SPrStart;
        end else begin
          state_d = SSjRd;
        end
      end
      SSrRd: state_d = SSrWr;
      SSrWr: begin
        wr.status = mpsu_pkg::StReceiving;
        wr.wanted = reply_q;
        req.we    = 1'b1;
        req.wdata = wr;
        state_d   = SPnA;
      end

      // Block the sender and append it to the destination's sender queue.
      SSjRd: state_d = SSjWr;
      SSjWr: begin
        wr.status = (act_q == mpsu_pkg::ActSend) ? mpsu_pkg::StSending : mpsu_pkg::StSendRec;
        wr.wanted = type_q;
        wr.link   = mpsu_pkg::LinkNil;
        req.we    = 1'b1;
        req.wdata = wr;
        state_d   = SJsRd;
      end
      SJsRd: begin
        req.raddr = dest_q;
        state_d   = SJsChk;
      end
      SJsChk: begin
        req.raddr = rd.sqh[PidW-1:0];
        if (rd.sqh[PidW]) begin
          wr.sqh    = {1'b0, cur_q};
          req.we    = 1'b1;
          req.waddr = dest_q;
          req.wdata = wr;
          state_d   = SPnA;
        end else begin
          ptr_d   = rd.sqh[PidW-1:0];
          steps_d = '0;
          state_d = SJsWalk;
        end
      end
      SJsWalk: begin
        req.raddr = rd.link[PidW-1:0];
        if (!rd.link[PidW] && (steps_q < CntW'(mpsu_pkg::MaxProcs))) begin
          ptr_d   = rd.link[PidW-1:0];
          steps_d = steps_n;
        end else begin
          wr.link   = {1'b0, cur_q};
          req.we    = 1'b1;
          req.waddr = ptr_q;
          req.wdata = wr;
          state_d   = SPnA;
        end
      end

      // Receive: pending interrupt first, then search the sender queue.
      SRcChk: begin
        req.raddr = rd.sqh[PidW-1:0];
        if (rd.pend && (any_t || (type_q == intr_q))) begin
          wr.pend   = 1'b0;
          req.we    = 1'b1;
          req.wdata = wr;
          dlv_d     = 1'b1;
          dto_d     = cur_q;
          hw_d      = 1'b1;
          dtype_d   = intr_q;
          state_d   = SFin;
        end else if ((type_q != intr_q) && !rd.sqh[PidW]) begin
          ptr_d   = rd.sqh[PidW-1:0];
          prev_d  = mpsu_pkg::LinkNil;
          steps_d = '0;
          state_d = SRcWalk;
        end else begin
          state_d = SRcBkRd;
        end
      end
      SRcWalk: begin
        req.raddr = rd.link[PidW-1:0];
        if (any_t || (rd.wanted == type_q)) begin
          ent_d   = rd;
          dlv_d   = 1'b1;
          dto_d   = cur_q;
          dfrom_d = ptr_q;
          dtype_d = rd.wanted;
          state_d = SRcUlRd;
        end else begin
          prev_d = {1'b0, ptr_q};
          if (rd.link[PidW] || (steps_n >= CntW'(mpsu_pkg::MaxProcs))) begin
            state_d = SRcBkRd;
          end else begin
            ptr_d   = rd.link[PidW-1:0];
            steps_d = steps_n;
          end
        end
      end
      SRcUlRd: begin
        req.raddr = prev_q[PidW] ? cur_q : prev_q[PidW-1:0];
        state_d   = SRcUlWr;
      end
      SRcUlWr: begin
        // Unlink the matched sender from its predecessor or the queue head.
        if (prev_q[PidW]) begin
          wr.sqh = ent_q.link;
        end else begin
          wr.link = ent_q.link;
        end
        req.we    = 1'b1;
        req.waddr = prev_q[PidW] ? cur_q : prev_q[PidW-1:0];
        req.wdata = wr;
        if (ent_q.status == mpsu_pkg::StSending) begin
          pp_d    = ptr_q;
          pprio_d = ent_q.prio;
          ret_d   = SFin;
          state_d = SPrStart;
        end else begin
          state_d = SRcSRd;
        end
      end
      SRcSRd: begin
        req.raddr = ptr_q;
        state_d   = SRcSWr;
      end
      SRcSWr: begin
        wr.status = mpsu_pkg::StReceiving;
        wr.wanted = reply_q;
        req.we    = 1'b1;
        req.waddr = ptr_q;
        req.wdata = wr;
        state_d   = SFin;
      end
      SRcBkRd: state_d = SRcBkWr;
      SRcBkWr: begin
        wr.status = mpsu_pkg::StReceiving;
        wr.wanted = type_q;
        req.we    = 1'b1;
        req.wdata = wr;
        state_d   = SPnA;
      end

      SExWr: begin
        wr.status = mpsu_pkg::StDead;
        req.we    = 1'b1;
        req.wdata = wr;
        state_d   = SPnA;
      end
      SCnWr: begin
        wr.prio         = '0;
        req.we          = 1'b1;
        req.wdata       = wr;
        hdl_d[irq_idx]  = cur_q;
        state_d         = SFin;
      end
      SSpWr: begin
        wr.prio   = PrioW'(pval_q);
        req.we    = 1'b1;
        req.wdata = wr;
        state_d   = SFin;
      end

      // Interrupt: wake the handler at top priority, or flag it pending.
      SInChk: begin
        if (takes(rd, intr_q, any_q)) begin
          dlv_d   = 1'b1;
          dto_d   = hdl_q[irq_idx];
          hw_d    = 1'b1;
          dtype_d = intr_q;
          pp_d    = hdl_q[irq_idx];
          pprio_d = '0;
          ret_d   = SInCur;
          state_d = SPrStart;
        end else begin
          wr.pend   = 1'b1;
          req.we    = 1'b1;
          req.waddr = hdl_q[irq_idx];
          req.wdata = wr;
          state_d   = SFin;
        end
      end
      SInCur: state_d = SInCur2;
      SInCur2: begin
        if (rd.prio != '0) begin
          pp_d    = cur_q;
          pprio_d = rd.prio;
          ret_d   = SPnA;
          state_d = SPrStart;
        end else begin
          state_d = SFin;
        end
      end

      SFin: begin
        if (!ov_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      ret_q     <= SFin;
      running_q <= '0;
      count_q   <= CntW'(1);
      for (int i = 0; i < mpsu_pkg::NumPrio; i++) begin
        head_q[i] <= mpsu_pkg::LinkNil;
        tail_q[i] <= mpsu_pkg::LinkNil;
      end
      for (int i = 0; i < mpsu_pkg::NumIrqs; i++) begin
        hdl_q[i] <= '0;
      end
      any_q     <= mpsu_pkg::AnyTypeReset;
      intr_q    <= mpsu_pkg::IntrTypeReset;
      reply_q   <= mpsu_pkg::ReplyTypeReset;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      running_q <= running_d;
      count_q   <= count_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      hdl_q     <= hdl_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          mpsu_pkg::CfgAnyType:   any_q   <= cfg_data_i;
          mpsu_pkg::CfgIntrType:  intr_q  <= cfg_data_i;
          mpsu_pkg::CfgReplyType: reply_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload and working registers: no reset needed.
  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    dest_q  <= dest_d;
    type_q  <= type_d;
    irq_q   <= irq_d;
    pval_q  <= pval_d;
    cur_q   <= cur_d;
    pp_q    <= pp_d;
    pprio_q <= pprio_d;
    ptr_q   <= ptr_d;
    prev_q  <= prev_d;
    steps_q <= steps_d;
    pnq_q   <= pnq_d;
    ent_q   <= ent_d;
    dlv_q   <= dlv_d;
    hw_q    <= hw_d;
    dto_q   <= dto_d;
    dfrom_q <= dfrom_d;
    npid_q  <= npid_d;
    dtype_q <= dtype_d;
    err_q   <= err_d;
    if (load_out) begin
      o_cur_q   <= 5'(running_q);
      o_dlv_q   <= dlv_q;
      o_dto_q   <= 5'(dto_q);
      o_dfrom_q <= 5'(dfrom_q);
      o_hw_q    <= hw_q;
      o_dtype_q <= dtype_q;
      o_npid_q  <= 5'(npid_q);
      o_err_q   <= err_q;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.current_pid   = o_cur_q;
  assign res_o.delivered     = o_dlv_q;
  assign res_o.deliver_to    = o_dto_q;
  assign res_o.deliver_from  = o_dfrom_q;
  assign res_o.from_hardware = o_hw_q;
  assign res_o.deliver_type  = o_dtype_q;
  assign res_o.new_pid       = o_npid_q;
  assign res_o.error         = o_err_q;

endmodule

FILE: test/mpsu_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsu_result_checker
// Watches the request, result and register write ports of the scheduler,
// predicts each result from its own copy of the process table and compares.
// ----------------------------------------------------------------------------
module mpsu_result_checker
  import mpsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mpsu_cmd_if        cmd,
  mpsu_res_if        res,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         outstanding_o,
  output int         fail_count_o
);

  localparam int Nil = MaxProcs;

  typedef struct packed {
    logic [4:0] current_pid;
    logic       delivered;
    logic [4:0] deliver_to;
    logic [4:0] deliver_from;
    logic       from_hardware;
    logic [7:0] deliver_type;
    logic [4:0] new_pid;
    err_e       error;
  } outcome_t;

  outcome_t   outcome_q[$];

  status_e          st[MaxProcs];
  logic [PrioW-1:0] pri[MaxProcs];
  logic [7:0]       want[MaxProcs];
  bit               pend[MaxProcs];
  int               lnk[MaxProcs];
  int               sqh[MaxProcs];
  int               rhead[NumPrio];
  int               rtail[NumPrio];
  int               handler[NumIrqs];
  int               running;
  int               nprocs;
  logic [7:0]       any_code, intr_code, reply_code;

  assign outstanding_o = outcome_q.size();

  function automatic void clear_table();
    any_code   = AnyTypeReset;
    intr_code  = IntrTypeReset;
    reply_code = ReplyTypeReset;
    for (int i = 0; i < MaxProcs; i++) begin
      st[i]   = StDead;
      pri[i]  = PrioW'(NumPrio - 1);
      want[i] = AnyTypeReset;
      pend[i] = 0;
      lnk[i]  = Nil;
      sqh[i]  = Nil;
    end
    st[0]  = StIdling;
    pri[0] = PrioW'(NumPrio);
    for (int q = 0; q < NumPrio; q++) begin
      rhead[q] = Nil;
      rtail[q] = Nil;
    end
    for (int i = 0; i < NumIrqs; i++) handler[i] = 0;
    running = 0;
    nprocs  = 1;
  endfunction

  function automatic void queue_ready(int p, int prio);
    if (p >= MaxProcs || prio >= NumPrio) return;
    st[p]  = StActive;
    lnk[p] = Nil;
    if (rhead[prio] >= MaxProcs || rtail[prio] >= MaxProcs) rhead[prio] = p;
    else lnk[rtail[prio]] = p;
    rtail[prio] = p;
  endfunction

  function automatic void choose_next();
    for (int q = 0; q < NumPrio; q++) begin
      if (rhead[q] < MaxProcs) begin
        running  = rhead[q];
        rhead[q] = lnk[running];
        return;
      end
    end
    running = 0;
  endfunction

  function automatic bit accepts(int d, logic [7:0] t);
    return st[d] == StReceiving && (want[d] == any_code || want[d] == t);
  endfunction

  function automatic outcome_t schedule(logic [3:0] act, logic [4:0] dest, logic [7:0] t,
                                        logic [4:0] irq, logic [1:0] prio);
    outcome_t o;
    int       cur, s, prv, r, h;
    bit       any;
    o   = '0;
    cur = running;
    case (act)
      ActCreate: begin
        if (nprocs >= MaxProcs) begin
          o.error = ErrTooMany;
        end else begin
          o.new_pid = 5'(nprocs);
          pri[nprocs]  = PrioW'(NumPrio - 1);
          want[nprocs] = any_code;
          pend[nprocs] = 0;
          sqh[nprocs]  = Nil;
          queue_ready(nprocs, NumPrio - 1);
          nprocs++;
        end
      end
      ActYield, ActPreempt: begin
        queue_ready(cur, pri[cur]);
        choose_next();
      end
      ActSend, ActSendRec: begin
        if (dest >= nprocs || st[dest] == StDead) begin
          o.error = ErrBadDest;
        end else if (accepts(dest, t)) begin
          o.delivered = 1; o.deliver_to = dest; o.deliver_from = 5'(cur);
          o.deliver_type = t;
          queue_ready(dest, pri[dest]);
          if (act == ActSendRec) begin
            st[cur]   = StReceiving;
            want[cur] = reply_code;
            choose_next();
          end
        end else begin
          st[cur]   = (act == ActSend) ? StSending : StSendRec;
          want[cur] = t;
          // append the caller to the tail of the destination's sender queue
          lnk[cur] = Nil;
          r = sqh[dest];
          if (r >= MaxProcs) begin
            sqh[dest] = cur;
          end else begin
            for (int k = 0; k < MaxProcs && lnk[r] < MaxProcs; k++) r = lnk[r];
            lnk[r] = cur;
          end
          choose_next();
        end
      end
      ActReceive: begin
        any = (t == any_code);
        if (pend[cur] && (any || t == intr_code)) begin
          pend[cur] = 0;
          o.delivered = 1; o.deliver_to = 5'(cur); o.from_hardware = 1;
          o.deliver_type = intr_code;
        end else begin
          if (t != intr_code) begin
            s   = sqh[cur];
            prv = Nil;
            for (int k = 0; k < MaxProcs && s < MaxProcs; k++) begin
              if (any || want[s] == t) begin
                if (prv == Nil) sqh[cur] = lnk[s];
                else lnk[prv] = lnk[s];
                o.delivered = 1; o.deliver_to = 5'(cur); o.deliver_from = 5'(s);
                o.deliver_type = want[s];
                if (st[s] == StSending) begin
                  queue_ready(s, pri[s]);
                end else begin
                  st[s]   = StReceiving;
                  want[s] = reply_code;
                end
                break;
              end
              prv = s;
              s   = lnk[s];
            end
          end
          if (!o.delivered) begin
            st[cur]   = StReceiving;
            want[cur] = t;
            choose_next();
          end
        end
      end
      ActExit: begin
        st[cur] = StDead;
        choose_next();
      end
      ActConnect: begin
        if (irq < NumIrqs) begin
          pri[cur]     = '0;
          handler[irq] = cur;
        end
      end
      ActSetPrio: begin
        if (prio > NumPrio - 1) o.error = ErrBadPrio;
        else pri[cur] = prio;
      end
      ActIntr: begin
        if (irq >= NumIrqs || handler[irq] == 0) begin
          o.error = ErrBadIntr;
        end else begin
          h = handler[irq];
          if (accepts(h, intr_code)) begin
            o.delivered = 1; o.deliver_to = 5'(h); o.from_hardware = 1;
            o.deliver_type = intr_code;
            queue_ready(h, 0);
            if (pri[cur] > 0) begin
              queue_ready(cur, pri[cur]);
              choose_next();
            end
          end else begin
            pend[h] = 1;
          end
        end
      end
      default: ;
    endcase
    o.current_pid = 5'(running);
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want_v);
    fail_count_o++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      clear_table();
      outcome_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgAnyType:   any_code   = cfg_data_i;
          CfgIntrType:  intr_code  = cfg_data_i;
          CfgReplyType: reply_code = cfg_data_i;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        outcome_q.push_back(schedule(cmd.action, cmd.target_pid, cmd.msg_type,
                                     cmd.irq_number, cmd.priority_value));
      if (res.valid && res.ready) begin
        if (outcome_q.size() == 0) begin
          report("unexpected result", res.current_pid, 0);
        end else begin
          exp_o = outcome_q.pop_front();
          if (res.current_pid !== exp_o.current_pid)
            report("current_pid", res.current_pid, exp_o.current_pid);
          if (res.delivered !== exp_o.delivered)
            report("delivered", res.delivered, exp_o.delivered);
          if (res.deliver_to !== exp_o.deliver_to)
            report("deliver_to", res.deliver_to, exp_o.deliver_to);
          if (res.deliver_from !== exp_o.deliver_from)
            report("deliver_from", res.deliver_from, exp_o.deliver_from);
          if (res.from_hardware !== exp_o.from_hardware)
            report("from_hardware", res.from_hardware, exp_o.from_hardware);
          if (res.deliver_type !== exp_o.deliver_type)
            report("deliver_type", res.deliver_type, exp_o.deliver_type);
          if (res.new_pid !== exp_o.new_pid)
            report("new_pid", res.new_pid, exp_o.new_pid);
          if (res.error !== exp_o.error)
            report("error", res.error, exp_o.error);
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives kernel requests and register writes into the scheduler under several
// idle patterns; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import mpsu_pkg::*;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       cfg_we_i = 0;
  logic [1:0] cfg_index_i = CfgAnyType;
  logic [7:0] cfg_data_i = '0;
  int         outstanding, fail_count;

  // idle percentages for the sender and the receiver in the current phase
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  // long receiver hold-off: raised by the stimulus, counted by the receiver
  bit         hold_go = 0;
  int         hold_cnt = 0;

  logic [7:0] any_cur = AnyTypeReset, intr_cur = IntrTypeReset, reply_cur = ReplyTypeReset;

  mpsu_cmd_if cmd ();
  mpsu_res_if res ();

  message_passing_process_scheduler_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .res_o       (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  mpsu_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd           (cmd),
    .res           (res),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    cmd.valid = 0; cmd.action = ActYield; cmd.target_pid = 0; cmd.msg_type = 0;
    cmd.irq_number = 0; cmd.priority_value = 0;
    res.ready = 0;
  end

  // Receiver: stall at random, or hold off for a long stretch when asked.
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      res.ready <= 0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one request, idling at random first; hold valid until accepted.
  task automatic issue(action_e act, logic [4:0] dest, logic [7:0] mt,
                       logic [4:0] irq, logic [1:0] prio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd.valid <= 0;
      @(posedge clk_i);
    end
    cmd.valid          <= 1;
    cmd.action         <= act;
    cmd.target_pid     <= dest;
    cmd.msg_type       <= mt;
    cmd.irq_number     <= irq;
    cmd.priority_value <= prio;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
  endtask

  // Drop valid, drain every result, then let the block settle.
  task automatic drain();
    cmd.valid <= 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we_i    <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
    case (idx)
      CfgAnyType:   any_cur = val;
      CfgIntrType:  intr_cur = val;
      CfgReplyType: reply_cur = val;
      default: ;
    endcase
  endtask

  // Pick a message type that often hits the register codes so rendezvous match.
  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 7))
      0, 1:    return any_cur;
      2:       return intr_cur;
      3:       return reply_cur;
      4, 5:    return 8'($urandom_range(3, 5));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_request();
    int         w;
    action_e    act;
    logic [4:0] dest, irq;
    w = $urandom_range(0, 99);
    if (w < 4)       act = ActCreate;
    else if (w < 14) act = ActYield;
    else if (w < 31) act = ActSend;
    else if (w < 49) act = ActReceive;
    else if (w < 59) act = ActSendRec;
    else if (w < 63) act = ActExit;
    else if (w < 68) act = ActConnect;
    else if (w < 75) act = ActSetPrio;
    else if (w < 88) act = ActIntr;
    else if (w < 97) act = ActPreempt;
    else             act = action_e'($urandom_range(10, 15));
    dest = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 9));
    irq  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
    issue(act, dest, pick_type(), irq, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: populate, bad destination and priority, interrupt without a
    // handler, handler wake-up with preemption, queued senders, unknown codes.
    repeat (4) issue(ActCreate, 0, 0, 0, 0);
    issue(ActSend, 31, 8'hff, 0, 0);
    issue(ActIntr, 0, 0, 31, 0);
    issue(ActYield, 0, 0, 0, 0);
    issue(ActSetPrio, 0, 0, 0, 2'd3);
    issue(ActConnect, 0, 0, 5'd31, 0);
    issue(ActConnect, 0, 0, 5'd5, 0);
    issue(ActReceive, 0, IntrTypeReset, 0, 0);
    issue(ActSend, 5'd1, 8'd0, 0, 0);
    issue(ActIntr, 0, 0, 5'd5, 0);
    issue(ActSendRec, 5'd2, 8'hff, 0, 0);
    issue(ActReceive, 0, 8'hff, 0, 0);
    issue(ActSend, 5'd3, 8'd7, 0, 0);
    issue(ActReceive, 0, 8'd7, 0, 0);
    issue(ActIntr, 0, 0, 5'd5, 0);
    issue(ActReceive, 0, 8'hff, 0, 0);
    issue(ActSetPrio, 0, 0, 0, 2'd0);
    issue(ActPreempt, 0, 0, 0, 0);
    issue(ActExit, 0, 0, 0, 0);
    issue(action_e'(4'd10), 5'd31, 8'hff, 5'd31, 2'd3);
    issue(action_e'(4'd15), 0, 0, 0, 0);
    drain();

    // Random phases with different idle patterns and register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_go = 1; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int n = 0; n < 100; n++) begin
        random_request();
        // once, let every expected result arrive before going on
        if (ph == 3 && n == 50) begin
          cmd.valid <= 0;
          @(posedge clk_i);
          while (outstanding != 0) @(posedge clk_i);
        end
      end
      drain();
      case (ph)
        0: begin write_reg(CfgAnyType, 8'd0); write_reg(CfgIntrType, 8'hff);
                 write_reg(CfgReplyType, 8'd0); end
        1: begin write_reg(CfgAnyType, 8'hff); write_reg(CfgIntrType, 8'd0);
                 write_reg(CfgReplyType, 8'hff); end
        2: begin write_reg(CfgAnyType, 8'($urandom_range(0, 255)));
                 write_reg(CfgIntrType, 8'($urandom_range(0, 255)));
                 write_reg(CfgReplyType, 8'($urandom_range(0, 255))); end
        default: begin write_reg(CfgAnyType, AnyTypeReset);
                 write_reg(CfgIntrType, IntrTypeReset);
                 write_reg(CfgReplyType, ReplyTypeReset); end
      endcase
    end

    // Fill the process table to its limit and beyond.
    send_idle_pct = 8; recv_stall_pct = 8;
    repeat (34) issue(ActCreate, 0, 0, 0, 0);
    repeat (20) random_request();
    drain();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
src/mpsu_pkg.sv
src/mpsu_if.sv
src/mpsu_ptab.sv
src/message_passing_process_scheduler_unit.sv
test/mpsu_result_checker.sv
test/tb.sv
